>>> src/pcode_stack_machine_execute_defines.svh
// ----------------------------------------------------------------------------
// pcode_stack_machine_execute_defines.svh
// Assertion macros for the p-code stack machine.
// ----------------------------------------------------------------------------
`ifndef PCODE_STACK_MACHINE_EXECUTE_DEFINES_SVH
`define PCODE_STACK_MACHINE_EXECUTE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PCSM_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcsm: implication check failed");
`define PCSM_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcsm: next-cycle check failed");
`else
`define PCSM_ASSERT_IMP(name, ante, cons)
`define PCSM_ASSERT_NEXT(name, ante, cons)
`endif

`endif

>>> src/pcsm_pkg.sv
// ----------------------------------------------------------------------------
// pcsm_pkg
// Types and constants shared by the p-code stack machine modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcsm_pkg;

	localparam int ADDR_W  = 12;
	localparam int WORD_W  = 32;
	localparam int PC_W    = 11;
	localparam int TOP_W   = 13;
	localparam int OPD_W   = 11;
	localparam int LEV_W   = 2;
	localparam int FUNC_W  = 3;
	localparam int FAULT_W = 2;
	localparam int DIV_CNT_W = 5;
	localparam int STACK_DEPTH = 1 << ADDR_W;

	localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
	localparam logic [ADDR_W-1:0] RET_B_MAX = ADDR_W'(STACK_DEPTH - 3);
	localparam logic signed [TOP_W-1:0] CAL_T_MAX = TOP_W'(STACK_DEPTH - 4);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(WORD_W - 1);

	localparam logic [OPD_W-1:0] OPR_RET = 11'd0;
	localparam logic [OPD_W-1:0] OPR_NEG = 11'd1;
	localparam logic [OPD_W-1:0] OPR_ADD = 11'd2;
	localparam logic [OPD_W-1:0] OPR_SUB = 11'd3;
	localparam logic [OPD_W-1:0] OPR_MUL = 11'd4;
	localparam logic [OPD_W-1:0] OPR_DIV = 11'd5;
	localparam logic [OPD_W-1:0] OPR_ODD = 11'd6;
	localparam logic [OPD_W-1:0] OPR_EQL = 11'd8;
	localparam logic [OPD_W-1:0] OPR_NEQ = 11'd9;
	localparam logic [OPD_W-1:0] OPR_LSS = 11'd10;
	localparam logic [OPD_W-1:0] OPR_GEQ = 11'd11;
	localparam logic [OPD_W-1:0] OPR_GTR = 11'd12;
	localparam logic [OPD_W-1:0] OPR_LEQ = 11'd13;

	localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
	localparam logic [FAULT_W-1:0] FAULT_DIV0 = 2'd1;
	localparam logic [FAULT_W-1:0] FAULT_ADDR = 2'd2;

	typedef enum logic [FUNC_W-1:0] {
		F_LIT, F_OPR, F_LOD, F_STO, F_CAL, F_INT, F_JMP, F_JPC
	} func_t;

	typedef enum logic [1:0] {OC_NOP, OC_RET, OC_UN, OC_BIN} opr_class_t;

	typedef enum logic [2:0] {
		RD_NONE, RD_B1, RD_B2, RD_T, RD_TM1, RD_WALK, RD_AD
	} rd_sel_t;

	typedef enum logic [3:0] {
		WR_NONE, WR_CLR, WR_T1_OPD, WR_T_UN, WR_TM1_RES, WR_T1_RD, WR_AD_RD,
		WR_T1_WALK, WR_T2_B, WR_T3_NP
	} wr_sel_t;

	typedef enum logic [2:0] {T_HOLD, T_INC, T_DEC, T_ADD_OPD, T_RET} t_op_t;
	typedef enum logic [1:0] {B_HOLD, B_RET, B_CAL} b_op_t;
	typedef enum logic [1:0] {NP_HOLD, NP_OPD, NP_RD, NP_OPD_IF_ZERO} np_op_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_RET1, ST_RET2, ST_UNARY, ST_BIN1,
		ST_BIN2, ST_EXEC, ST_DIV, ST_WB, ST_JPC, ST_WALK, ST_WALK_CHK, ST_ADDR,
		ST_LOD, ST_STO, ST_CAL2, ST_CAL3, ST_TOP_RD, ST_TOP_WAIT
	} state_t;

	typedef struct packed {
		logic    load_instr;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		t_op_t   t_op;
		b_op_t   b_op;
		np_op_t  np_op;
		logic    walk_init;
		logic    walk_step;
		logic    x_ld;
		logic    y_ld;
		logic    alu_ld;
		logic    div_start;
		logic    div_ld;
		logic    fault_bad;
		logic    commit_pc;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		func_t      func;
		opr_class_t opr_class;
		logic       t_max;
		logic       t_neg;
		logic       t_ge1;
		logic       ret_ok;
		logic       int_ok;
		logic       cal_ok;
		logic       ad_ok;
		logic       link_ok;
		logic       lev_zero;
		logic       div_run;
		logic       div_done;
		logic       clr_last;
	} sts_t;

endpackage

`default_nettype wire

>>> src/pcsm_instr_if.sv
// ----------------------------------------------------------------------------
// pcsm_instr_if
// Instruction channel: valid/ready with one p-code instruction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pcsm_instr_if;
	logic                          valid;
	logic                          ready;
	logic [pcsm_pkg::FUNC_W-1:0]   func;
	logic [pcsm_pkg::LEV_W-1:0]    level;
	logic [pcsm_pkg::OPD_W-1:0]    operand;

	modport source (output valid, output func, output level, output operand, input ready);
	modport sink (input valid, input func, input level, input operand, output ready);
endinterface

`default_nettype wire

>>> src/pcsm_result_if.sv
// ----------------------------------------------------------------------------
// pcsm_result_if
// Result channel: valid/ready with machine state after one instruction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pcsm_result_if;
	logic                                valid;
	logic                                ready;
	logic [pcsm_pkg::PC_W-1:0]           next_pc;
	logic                                halted;
	logic signed [pcsm_pkg::TOP_W-1:0]   top_index;
	logic signed [pcsm_pkg::WORD_W-1:0]  top_value;
	logic [pcsm_pkg::ADDR_W-1:0]         frame_base;
	logic [pcsm_pkg::FAULT_W-1:0]        fault;

	modport source (output valid, output next_pc, output halted, output top_index,
		output top_value, output frame_base, output fault, input ready);
	modport sink (input valid, input next_pc, input halted, input top_index,
		input top_value, input frame_base, input fault, output ready);
endinterface

`default_nettype wire

>>> src/pcode_stack_machine_execute.sv
// ----------------------------------------------------------------------------
// pcode_stack_machine_execute
// PL/0 p-code executor: one instruction in, one machine-state transaction out.
//
// instr carries func/level/operand; result carries next_pc, halted, top
// index and value, frame base and fault. Both use valid/ready.
// After reset the 4096-word stack is swept to zero, one word a cycle, so
// instr.ready stays low until the sweep has finished.
// Instructions run one at a time through a sequencer over a single-port
// stack memory (one read or write per cycle, read data registered).
// A divide yields one quotient bit per cycle; LOD, STO and CAL run longer
// for each static link followed; an address fault ends the sequence early.
// instr.ready rises in the cycle after the result register is loaded, so
// a new instruction is accepted only once the previous result is loaded.
// Results sit in an output register: a stalled receiver holds the result
// and the next instruction may be accepted meanwhile; its result waits
// until the register is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "pcode_stack_machine_execute_defines.svh"

module pcode_stack_machine_execute (
	input  wire logic     clk,
	input  wire logic     arst_n,
	pcsm_instr_if.sink    instr,
	pcsm_result_if.source result
);

	pcsm_pkg::cmd_t cmd;
	pcsm_pkg::sts_t sts;

	pcsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (instr.valid),
		.in_ready  (instr.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pcsm_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.func       (instr.func),
		.level      (instr.level),
		.operand    (instr.operand),
		.next_pc    (result.next_pc),
		.halted     (result.halted),
		.top_index  (result.top_index),
		.top_value  (result.top_value),
		.frame_base (result.frame_base),
		.fault      (result.fault)
	);

	`PCSM_ASSERT_NEXT(a_one_in_flight, instr.valid && instr.ready, !instr.ready)
	`PCSM_ASSERT_IMP(a_div0_zero, result.valid && result.fault == pcsm_pkg::FAULT_DIV0, result.top_value == '0)
	`PCSM_ASSERT_IMP(a_empty_zero, result.valid && result.top_index[pcsm_pkg::TOP_W-1], result.top_value == '0)

endmodule

`default_nettype wire

>>> src/pcsm_div.sv
// ----------------------------------------------------------------------------
// pcsm_div
// Signed restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcsm_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [pcsm_pkg::WORD_W-1:0]   dividend,
	input  wire logic [pcsm_pkg::WORD_W-1:0]   divisor,
	output logic                               done,
	output logic [pcsm_pkg::WORD_W-1:0]        quotient
);

	logic                                busy_q;
	logic                                done_q;
	logic [pcsm_pkg::DIV_CNT_W-1:0]      cnt_q;
	logic [pcsm_pkg::WORD_W-1:0]         rem_q;
	logic [pcsm_pkg::WORD_W-1:0]         quo_q;
	logic [pcsm_pkg::WORD_W-1:0]         den_q;
	logic                                neg_q;
	logic [pcsm_pkg::WORD_W:0]           trial;
	logic [pcsm_pkg::WORD_W-1:0]         mag_a;
	logic [pcsm_pkg::WORD_W-1:0]         mag_b;

	assign mag_a = dividend[pcsm_pkg::WORD_W-1] ? (~dividend + 1'b1) : dividend;
	assign mag_b = divisor[pcsm_pkg::WORD_W-1] ? (~divisor + 1'b1) : divisor;
	assign trial = {rem_q, quo_q[pcsm_pkg::WORD_W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == pcsm_pkg::DIV_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pcsm_pkg::DIV_LAST)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag_a;
			den_q <= mag_b;
			neg_q <= dividend[pcsm_pkg::WORD_W-1] ^ divisor[pcsm_pkg::WORD_W-1];
		end else if (busy_q) begin
			if (!trial[pcsm_pkg::WORD_W])
				rem_q <= trial[pcsm_pkg::WORD_W-1:0];
			else
				rem_q <= {rem_q[pcsm_pkg::WORD_W-2:0], quo_q[pcsm_pkg::WORD_W-1]};
			quo_q <= {quo_q[pcsm_pkg::WORD_W-2:0], ~trial[pcsm_pkg::WORD_W]};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

`default_nettype wire

>>> src/pcsm_datapath.sv
// ----------------------------------------------------------------------------
// pcsm_datapath
// Machine registers, stack memory, ALU and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcsm_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire pcsm_pkg::cmd_t                      cmd,
	output pcsm_pkg::sts_t                           sts,
	input  wire logic [pcsm_pkg::FUNC_W-1:0]         func,
	input  wire logic [pcsm_pkg::LEV_W-1:0]          level,
	input  wire logic [pcsm_pkg::OPD_W-1:0]          operand,
	output logic [pcsm_pkg::PC_W-1:0]                next_pc,
	output logic                                     halted,
	output logic signed [pcsm_pkg::TOP_W-1:0]        top_index,
	output logic signed [pcsm_pkg::WORD_W-1:0]       top_value,
	output logic [pcsm_pkg::ADDR_W-1:0]              frame_base,
	output logic [pcsm_pkg::FAULT_W-1:0]             fault
);

	logic [pcsm_pkg::WORD_W-1:0]          mem [pcsm_pkg::STACK_DEPTH];
	logic [pcsm_pkg::WORD_W-1:0]          rdata_q;

	logic [pcsm_pkg::PC_W-1:0]            pc_q;
	logic [pcsm_pkg::PC_W-1:0]            np_q;
	logic [pcsm_pkg::ADDR_W-1:0]          b_q;
	logic signed [pcsm_pkg::TOP_W-1:0]    t_q;
	logic [pcsm_pkg::ADDR_W-1:0]          clr_q;

	pcsm_pkg::func_t                      func_q;
	logic [pcsm_pkg::LEV_W-1:0]           lev_q;
	logic [pcsm_pkg::OPD_W-1:0]           opd_q;
	logic [pcsm_pkg::LEV_W-1:0]           lev_cnt_q;
	logic [pcsm_pkg::ADDR_W-1:0]          walk_q;
	logic [pcsm_pkg::WORD_W-1:0]          x_q;
	logic [pcsm_pkg::WORD_W-1:0]          y_q;
	logic [pcsm_pkg::WORD_W-1:0]          res_q;
	logic [pcsm_pkg::FAULT_W-1:0]         fault_q;

	logic [pcsm_pkg::PC_W-1:0]            out_pc_q;
	logic                                 out_halt_q;
	logic signed [pcsm_pkg::TOP_W-1:0]    out_t_q;
	logic [pcsm_pkg::WORD_W-1:0]          out_val_q;
	logic [pcsm_pkg::ADDR_W-1:0]          out_b_q;
	logic [pcsm_pkg::FAULT_W-1:0]         out_fault_q;

	logic signed [pcsm_pkg::TOP_W-1:0]    t_p1, t_m1, t_p2, t_p3;
	logic [pcsm_pkg::TOP_W-1:0]           ad;
	logic [pcsm_pkg::TOP_W:0]             tsum;
	logic [pcsm_pkg::ADDR_W-1:0]          rd_addr;
	logic                                 rd_en;
	logic [pcsm_pkg::ADDR_W-1:0]          wr_addr;
	logic [pcsm_pkg::WORD_W-1:0]          wr_data;
	logic                                 wr_en;
	logic [pcsm_pkg::WORD_W-1:0]          un_res;
	logic [pcsm_pkg::WORD_W-1:0]          alu_res;
	logic [2*pcsm_pkg::WORD_W-1:0]        prod;
	logic                                 lss, gtr, eql;
	logic                                 div_done;
	logic [pcsm_pkg::WORD_W-1:0]          div_q;

	pcsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (x_q),
		.divisor  (y_q),
		.done     (div_done),
		.quotient (div_q)
	);

	assign t_p1 = t_q + 13'sd1;
	assign t_m1 = t_q - 13'sd1;
	assign t_p2 = t_q + 13'sd2;
	assign t_p3 = t_q + 13'sd3;
	assign ad   = pcsm_pkg::TOP_W'(walk_q) + pcsm_pkg::TOP_W'(opd_q);
	assign tsum = {t_q[pcsm_pkg::TOP_W-1], t_q} + (pcsm_pkg::TOP_W+1)'(opd_q);

	// status
	always_comb begin
		sts.func     = func_q;
		sts.t_max    = t_q == {1'b0, pcsm_pkg::ADDR_MAX};
		sts.t_neg    = t_q[pcsm_pkg::TOP_W-1];
		sts.t_ge1    = !t_q[pcsm_pkg::TOP_W-1] && (t_q != '0);
		sts.ret_ok   = b_q <= pcsm_pkg::RET_B_MAX;
		sts.int_ok   = tsum[pcsm_pkg::TOP_W] || !tsum[pcsm_pkg::TOP_W-1];
		sts.cal_ok   = t_q <= pcsm_pkg::CAL_T_MAX;
		sts.ad_ok    = !ad[pcsm_pkg::TOP_W-1];
		sts.link_ok  = rdata_q[pcsm_pkg::WORD_W-1:pcsm_pkg::ADDR_W] == '0;
		sts.lev_zero = lev_cnt_q == '0;
		sts.div_run  = (opd_q == pcsm_pkg::OPR_DIV) && (y_q != '0);
		sts.div_done = div_done;
		sts.clr_last = clr_q == pcsm_pkg::ADDR_MAX;
		if (opd_q == pcsm_pkg::OPR_RET)
			sts.opr_class = pcsm_pkg::OC_RET;
		else if (opd_q == pcsm_pkg::OPR_NEG || opd_q == pcsm_pkg::OPR_ODD)
			sts.opr_class = pcsm_pkg::OC_UN;
		else if ((opd_q >= pcsm_pkg::OPR_ADD && opd_q <= pcsm_pkg::OPR_DIV) ||
				(opd_q >= pcsm_pkg::OPR_EQL && opd_q <= pcsm_pkg::OPR_LEQ))
			sts.opr_class = pcsm_pkg::OC_BIN;
		else
			sts.opr_class = pcsm_pkg::OC_NOP;
	end

	// memory address and data select
	always_comb begin
		rd_en = 1'b1;
		case (cmd.rd_sel)
			pcsm_pkg::RD_B1:   rd_addr = b_q + 1'b1;
			pcsm_pkg::RD_B2:   rd_addr = b_q + 2'd2;
			pcsm_pkg::RD_T:    rd_addr = t_q[pcsm_pkg::ADDR_W-1:0];
			pcsm_pkg::RD_TM1:  rd_addr = t_m1[pcsm_pkg::ADDR_W-1:0];
			pcsm_pkg::RD_WALK: rd_addr = walk_q;
			pcsm_pkg::RD_AD:   rd_addr = ad[pcsm_pkg::ADDR_W-1:0];
			default: begin
				rd_addr = '0;
				rd_en   = 1'b0;
			end
		endcase
	end

	always_comb begin
		wr_en = 1'b1;
		case (cmd.wr_sel)
			pcsm_pkg::WR_CLR: begin
				wr_addr = clr_q;
				wr_data = '0;
			end
			pcsm_pkg::WR_T1_OPD: begin
				wr_addr = t_p1[pcsm_pkg::ADDR_W-1:0];
				wr_data = pcsm_pkg::WORD_W'(opd_q);
			end
			pcsm_pkg::WR_T_UN: begin
				wr_addr = t_q[pcsm_pkg::ADDR_W-1:0];
				wr_data = un_res;
			end
			pcsm_pkg::WR_TM1_RES: begin
				wr_addr = t_m1[pcsm_pkg::ADDR_W-1:0];
				wr_data = res_q;
			end
			pcsm_pkg::WR_T1_RD: begin
				wr_addr = t_p1[pcsm_pkg::ADDR_W-1:0];
				wr_data = rdata_q;
			end
			pcsm_pkg::WR_AD_RD: begin
				wr_addr = ad[pcsm_pkg::ADDR_W-1:0];
				wr_data = rdata_q;
			end
			pcsm_pkg::WR_T1_WALK: begin
				wr_addr = t_p1[pcsm_pkg::ADDR_W-1:0];
				wr_data = pcsm_pkg::WORD_W'(walk_q);
			end
			pcsm_pkg::WR_T2_B: begin
				wr_addr = t_p2[pcsm_pkg::ADDR_W-1:0];
				wr_data = pcsm_pkg::WORD_W'(b_q);
			end
			pcsm_pkg::WR_T3_NP: begin
				wr_addr = t_p3[pcsm_pkg::ADDR_W-1:0];
				wr_data = pcsm_pkg::WORD_W'(np_q);
			end
			default: begin
				wr_addr = '0;
				wr_data = '0;
				wr_en   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	// ALU
	assign un_res = (opd_q == pcsm_pkg::OPR_NEG) ? (~rdata_q + 1'b1)
		: pcsm_pkg::WORD_W'(rdata_q[0]);
	assign prod = x_q * y_q;
	assign lss  = $signed(x_q) < $signed(y_q);
	assign gtr  = $signed(y_q) < $signed(x_q);
	assign eql  = x_q == y_q;

	always_comb begin
		case (opd_q)
			pcsm_pkg::OPR_ADD: alu_res = x_q + y_q;
			pcsm_pkg::OPR_SUB: alu_res = x_q - y_q;
			pcsm_pkg::OPR_MUL: alu_res = prod[pcsm_pkg::WORD_W-1:0];
			pcsm_pkg::OPR_EQL: alu_res = pcsm_pkg::WORD_W'(eql);
			pcsm_pkg::OPR_NEQ: alu_res = pcsm_pkg::WORD_W'(!eql);
			pcsm_pkg::OPR_LSS: alu_res = pcsm_pkg::WORD_W'(lss);
			pcsm_pkg::OPR_GEQ: alu_res = pcsm_pkg::WORD_W'(!lss);
			pcsm_pkg::OPR_GTR: alu_res = pcsm_pkg::WORD_W'(gtr);
			pcsm_pkg::OPR_LEQ: alu_res = pcsm_pkg::WORD_W'(!gtr);
			default:           alu_res = '0;
		endcase
	end

	// architectural and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= '0;
			np_q      <= '0;
			b_q       <= '0;
			t_q       <= '1;
			clr_q     <= '0;
			lev_cnt_q <= '0;
			fault_q   <= pcsm_pkg::FAULT_NONE;
		end else begin
			if (cmd.wr_sel == pcsm_pkg::WR_CLR)
				clr_q <= clr_q + 1'b1;
			if (cmd.load_instr) begin
				np_q    <= pc_q + 1'b1;
				fault_q <= pcsm_pkg::FAULT_NONE;
			end
			case (cmd.np_op)
				pcsm_pkg::NP_OPD: np_q <= opd_q;
				pcsm_pkg::NP_RD:  np_q <= rdata_q[pcsm_pkg::PC_W-1:0];
				pcsm_pkg::NP_OPD_IF_ZERO: begin
					if (rdata_q == '0)
						np_q <= opd_q;
				end
				default: ;
			endcase
			case (cmd.t_op)
				pcsm_pkg::T_INC:     t_q <= t_p1;
				pcsm_pkg::T_DEC:     t_q <= t_m1;
				pcsm_pkg::T_ADD_OPD: t_q <= tsum[pcsm_pkg::TOP_W-1:0];
				pcsm_pkg::T_RET:     t_q <= pcsm_pkg::TOP_W'(b_q) - 13'sd1;
				default: ;
			endcase
			case (cmd.b_op)
				pcsm_pkg::B_RET: b_q <= x_q[pcsm_pkg::ADDR_W-1:0];
				pcsm_pkg::B_CAL: b_q <= t_p1[pcsm_pkg::ADDR_W-1:0];
				default: ;
			endcase
			if (cmd.walk_init)
				lev_cnt_q <= lev_q;
			else if (cmd.walk_step)
				lev_cnt_q <= lev_cnt_q - 1'b1;
			if (cmd.fault_bad)
				fault_q <= pcsm_pkg::FAULT_ADDR;
			else if (cmd.alu_ld && opd_q == pcsm_pkg::OPR_DIV)
				fault_q <= pcsm_pkg::FAULT_DIV0;
			if (cmd.commit_pc)
				pc_q <= np_q;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_instr) begin
			func_q <= pcsm_pkg::func_t'(func);
			lev_q  <= level;
			opd_q  <= operand;
		end
		if (cmd.walk_init)
			walk_q <= b_q;
		else if (cmd.walk_step)
			walk_q <= rdata_q[pcsm_pkg::ADDR_W-1:0];
		if (cmd.x_ld)
			x_q <= rdata_q;
		if (cmd.y_ld)
			y_q <= rdata_q;
		if (cmd.alu_ld)
			res_q <= alu_res;
		else if (cmd.div_ld)
			res_q <= div_q;
		if (cmd.out_load) begin
			out_pc_q    <= pc_q;
			out_halt_q  <= pc_q == '0;
			out_t_q     <= t_q;
			out_val_q   <= t_q[pcsm_pkg::TOP_W-1] ? '0 : rdata_q;
			out_b_q     <= b_q;
			out_fault_q <= fault_q;
		end
	end

	assign next_pc    = out_pc_q;
	assign halted     = out_halt_q;
	assign top_index  = out_t_q;
	assign top_value  = out_val_q;
	assign frame_base = out_b_q;
	assign fault      = out_fault_q;

endmodule

`default_nettype wire

>>> src/pcsm_ctrl.sv
// ----------------------------------------------------------------------------
// pcsm_ctrl
// Sequencer: steps each instruction through checks, reads and writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcsm_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire pcsm_pkg::sts_t   sts,
	output pcsm_pkg::cmd_t        cmd
);

	pcsm_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pcsm_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			pcsm_pkg::ST_CLEAR: begin
				cmd.wr_sel = pcsm_pkg::WR_CLR;
				if (sts.clr_last)
					state_d = pcsm_pkg::ST_IDLE;
			end
			pcsm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_instr = 1'b1;
					state_d        = pcsm_pkg::ST_DISPATCH;
				end
			end
			pcsm_pkg::ST_DISPATCH: begin
				state_d = pcsm_pkg::ST_TOP_RD;
				case (sts.func)
					pcsm_pkg::F_LIT: begin
						if (sts.t_max)
							cmd.fault_bad = 1'b1;
						else begin
							cmd.wr_sel = pcsm_pkg::WR_T1_OPD;
							cmd.t_op   = pcsm_pkg::T_INC;
						end
					end
					pcsm_pkg::F_OPR: begin
						case (sts.opr_class)
							pcsm_pkg::OC_RET: begin
								if (!sts.ret_ok)
									cmd.fault_bad = 1'b1;
								else begin
									cmd.rd_sel = pcsm_pkg::RD_B1;
									state_d    = pcsm_pkg::ST_RET1;
								end
							end
							pcsm_pkg::OC_UN: begin
								if (sts.t_neg)
									cmd.fault_bad = 1'b1;
								else begin
									cmd.rd_sel = pcsm_pkg::RD_T;
									state_d    = pcsm_pkg::ST_UNARY;
								end
							end
							pcsm_pkg::OC_BIN: begin
								if (!sts.t_ge1)
									cmd.fault_bad = 1'b1;
								else begin
									cmd.rd_sel = pcsm_pkg::RD_TM1;
									state_d    = pcsm_pkg::ST_BIN1;
								end
							end
							default: ;
						endcase
					end
					pcsm_pkg::F_LOD, pcsm_pkg::F_STO, pcsm_pkg::F_CAL: begin
						cmd.walk_init = 1'b1;
						state_d       = pcsm_pkg::ST_WALK;
					end
					pcsm_pkg::F_INT: begin
						if (!sts.int_ok)
							cmd.fault_bad = 1'b1;
						else
							cmd.t_op = pcsm_pkg::T_ADD_OPD;
					end
					pcsm_pkg::F_JMP: cmd.np_op = pcsm_pkg::NP_OPD;
					pcsm_pkg::F_JPC: begin
						if (sts.t_neg)
							cmd.fault_bad = 1'b1;
						else begin
							cmd.rd_sel = pcsm_pkg::RD_T;
							state_d    = pcsm_pkg::ST_JPC;
						end
					end
					default: ;
				endcase
			end
			pcsm_pkg::ST_RET1: begin
				if (!sts.link_ok) begin
					cmd.fault_bad = 1'b1;
					state_d       = pcsm_pkg::ST_TOP_RD;
				end else begin
					cmd.x_ld   = 1'b1;
					cmd.rd_sel = pcsm_pkg::RD_B2;
					state_d    = pcsm_pkg::ST_RET2;
				end
			end
			pcsm_pkg::ST_RET2: begin
				cmd.np_op = pcsm_pkg::NP_RD;
				cmd.t_op  = pcsm_pkg::T_RET;
				cmd.b_op  = pcsm_pkg::B_RET;
				state_d   = pcsm_pkg::ST_TOP_RD;
			end
			pcsm_pkg::ST_UNARY: begin
				cmd.wr_sel = pcsm_pkg::WR_T_UN;
				state_d    = pcsm_pkg::ST_TOP_RD;
			end
			pcsm_pkg::ST_BIN1: begin
				cmd.x_ld   = 1'b1;
				cmd.rd_sel = pcsm_pkg::RD_T;
				state_d    = pcsm_pkg::ST_BIN2;
			end
			pcsm_pkg::ST_BIN2: begin
				cmd.y_ld = 1'b1;
				state_d  = pcsm_pkg::ST_EXEC;
			end
			pcsm_pkg::ST_EXEC: begin
				if (sts.div_run) begin
					cmd.div_start = 1'b1;
					state_d       = pcsm_pkg::ST_DIV;
				end else begin
					cmd.alu_ld = 1'b1;
					state_d    = pcsm_pkg::ST_WB;
				end
			end
			pcsm_pkg::ST_DIV: begin
				if (sts.div_done) begin
					cmd.div_ld = 1'b1;
					state_d    = pcsm_pkg::ST_WB;
				end
			end
			pcsm_pkg::ST_WB: begin
				cmd.wr_sel = pcsm_pkg::WR_TM1_RES;
				cmd.t_op   = pcsm_pkg::T_DEC;
				state_d    = pcsm_pkg::ST_TOP_RD;
			end
			pcsm_pkg::ST_JPC: begin
				cmd.np_op = pcsm_pkg::NP_OPD_IF_ZERO;
				cmd.t_op  = pcsm_pkg::T_DEC;
				state_d   = pcsm_pkg::ST_TOP_RD;
			end
			pcsm_pkg::ST_WALK: begin
				if (sts.lev_zero)
					state_d = pcsm_pkg::ST_ADDR;
				else begin
					cmd.rd_sel = pcsm_pkg::RD_WALK;
					state_d    = pcsm_pkg::ST_WALK_CHK;
				end
			end
			pcsm_pkg::ST_WALK_CHK: begin
				if (!sts.link_ok) begin
					cmd.fault_bad = 1'b1;
					state_d       = pcsm_pkg::ST_TOP_RD;
				end else begin
					cmd.walk_step = 1'b1;
					state_d       = pcsm_pkg::ST_WALK;
				end
			end
			pcsm_pkg::ST_ADDR: begin
				state_d = pcsm_pkg::ST_TOP_RD;
				case (sts.func)
					pcsm_pkg::F_LOD: begin
						if (!sts.ad_ok || sts.t_max)
							cmd.fault_bad = 1'b1;
						else begin
							cmd.rd_sel = pcsm_pkg::RD_AD;
							state_d    = pcsm_pkg::ST_LOD;
						end
					end
					pcsm_pkg::F_STO: begin
						if (!sts.ad_ok || sts.t_neg)
							cmd.fault_bad = 1'b1;
						else begin
							cmd.rd_sel = pcsm_pkg::RD_T;
							state_d    = pcsm_pkg::ST_STO;
						end
					end
					default: begin
						if (!sts.cal_ok)
							cmd.fault_bad = 1'b1;
						else begin
							cmd.wr_sel = pcsm_pkg::WR_T1_WALK;
							state_d    = pcsm_pkg::ST_CAL2;
						end
					end
				endcase
			end
			pcsm_pkg::ST_LOD: begin
				cmd.wr_sel = pcsm_pkg::WR_T1_RD;
				cmd.t_op   = pcsm_pkg::T_INC;
				state_d    = pcsm_pkg::ST_TOP_RD;
			end
			pcsm_pkg::ST_STO: begin
				cmd.wr_sel = pcsm_pkg::WR_AD_RD;
				cmd.t_op   = pcsm_pkg::T_DEC;
				state_d    = pcsm_pkg::ST_TOP_RD;
			end
			pcsm_pkg::ST_CAL2: begin
				cmd.wr_sel = pcsm_pkg::WR_T2_B;
				state_d    = pcsm_pkg::ST_CAL3;
			end
			pcsm_pkg::ST_CAL3: begin
				cmd.wr_sel = pcsm_pkg::WR_T3_NP;
				cmd.b_op   = pcsm_pkg::B_CAL;
				cmd.np_op  = pcsm_pkg::NP_OPD;
				state_d    = pcsm_pkg::ST_TOP_RD;
			end
			pcsm_pkg::ST_TOP_RD: begin
				cmd.commit_pc = 1'b1;
				cmd.rd_sel    = pcsm_pkg::RD_T;
				state_d       = pcsm_pkg::ST_TOP_WAIT;
			end
			pcsm_pkg::ST_TOP_WAIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = pcsm_pkg::ST_IDLE;
				end
			end
			default: state_d = pcsm_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> tb/pcsm_exec_checker.sv
// ----------------------------------------------------------------------------
// pcsm_exec_checker
// Watches the instruction and result channels of the p-code executor. It
// keeps its own copy of the stack, program counter, base and top registers,
// works out the machine state each accepted instruction should report,
// and compares every result transaction field by field with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcsm_exec_checker
	import pcsm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	pcsm_instr_if     instr,
	pcsm_result_if    result,
	output int        errors,
	output int        pending,
	output int        results_seen
);

	typedef struct packed {
		logic [PC_W-1:0]          next_pc;
		logic                     halted;
		logic signed [TOP_W-1:0]  top_index;
		logic signed [WORD_W-1:0] top_value;
		logic [ADDR_W-1:0]        frame_base;
		logic [FAULT_W-1:0]       fault;
	} mstate_t;

	logic [WORD_W-1:0] stk [STACK_DEPTH];
	int pc_r, base_r, top_r;
	mstate_t state_q[$];

	function automatic int word_to_addr(logic [WORD_W-1:0] w);
		if ($signed(w) < 0)
			return -1;
		if (w >= STACK_DEPTH)
			return STACK_DEPTH;
		return int'(w);
	endfunction

	function automatic bit in_stk(int a);
		return a >= 0 && a < STACK_DEPTH;
	endfunction

	function automatic int follow_links(int b, int lev);
		for (int i = 0; i < lev; i++) begin
			if (!in_stk(b))
				return -1;
			b = word_to_addr(stk[b]);
		end
		return in_stk(b) ? b : -1;
	endfunction

	task automatic execute(input func_t f, input int lev, input logic [OPD_W-1:0] opd,
		output mstate_t st);
		int t, b, p, ba, ad, nb;
		bit bad;
		logic [FAULT_W-1:0] flt;
		logic [WORD_W-1:0] x, y, r;
		longint q;
		t = top_r;
		b = base_r;
		p = (pc_r + 1) % (1 << PC_W);
		bad = 0;
		flt = FAULT_NONE;
		r = '0;
		case (f)
			F_LIT: begin
				if (!in_stk(t + 1)) bad = 1;
				else begin
					t++;
					stk[t] = WORD_W'(opd);
				end
			end
			F_OPR: begin
				if (opd == OPR_RET) begin
					if (!in_stk(b + 2)) bad = 1;
					else begin
						nb = word_to_addr(stk[b + 1]);
						if (!in_stk(nb)) bad = 1;
						else begin
							p = int'(stk[b + 2][PC_W-1:0]);
							t = b - 1;
							b = nb;
						end
					end
				end else if (opd == OPR_NEG || opd == OPR_ODD) begin
					if (!in_stk(t)) bad = 1;
					else if (opd == OPR_NEG) stk[t] = -stk[t];
					else stk[t] = {{(WORD_W-1){1'b0}}, stk[t][0]};
				end else if ((opd >= OPR_ADD && opd <= OPR_DIV) ||
						(opd >= OPR_EQL && opd <= OPR_LEQ)) begin
					if (!in_stk(t - 1) || !in_stk(t)) bad = 1;
					else begin
						x = stk[t - 1];
						y = stk[t];
						case (opd)
							OPR_ADD: r = x + y;
							OPR_SUB: r = x - y;
							OPR_MUL: r = x * y;
							OPR_DIV: begin
								if (y == 0) begin
									r = '0;
									flt = FAULT_DIV0;
								end else begin
									q = longint'($signed(x)) / longint'($signed(y));
									r = q[WORD_W-1:0];
								end
							end
							OPR_EQL: r = WORD_W'(x == y);
							OPR_NEQ: r = WORD_W'(x != y);
							OPR_LSS: r = WORD_W'($signed(x) < $signed(y));
							OPR_GEQ: r = WORD_W'($signed(x) >= $signed(y));
							OPR_GTR: r = WORD_W'($signed(x) > $signed(y));
							default: r = WORD_W'($signed(x) <= $signed(y));
						endcase
						t--;
						stk[t] = r;
					end
				end
			end
			F_LOD, F_STO: begin
				ba = follow_links(b, lev);
				ad = ba + int'(opd);
				if (ba < 0 || !in_stk(ad)) bad = 1;
				else if (f == F_LOD) begin
					if (!in_stk(t + 1)) bad = 1;
					else begin
						stk[t + 1] = stk[ad];
						t++;
					end
				end else begin
					if (!in_stk(t)) bad = 1;
					else begin
						stk[ad] = stk[t];
						t--;
					end
				end
			end
			F_CAL: begin
				ba = follow_links(b, lev);
				if (ba < 0 || !in_stk(t + 3)) bad = 1;
				else begin
					stk[t + 1] = WORD_W'(ba);
					stk[t + 2] = WORD_W'(b);
					stk[t + 3] = WORD_W'(p);
					b = t + 1;
					p = int'(opd);
				end
			end
			F_INT: begin
				if (t + int'(opd) >= STACK_DEPTH) bad = 1;
				else t += int'(opd);
			end
			F_JMP: p = int'(opd);
			default: begin
				if (!in_stk(t)) bad = 1;
				else begin
					if (stk[t] == 0) p = int'(opd);
					t--;
				end
			end
		endcase
		if (bad) begin
			flt = FAULT_ADDR;
			t = top_r;
			b = base_r;
			p = (pc_r + 1) % (1 << PC_W);
		end
		pc_r = p;
		base_r = b;
		top_r = t;
		st.next_pc = PC_W'(p);
		st.halted = (p == 0);
		st.top_index = TOP_W'(t);
		st.top_value = in_stk(t) ? stk[t] : '0;
		st.frame_base = ADDR_W'(b);
		st.fault = flt;
	endtask

	initial begin
		foreach (stk[i]) stk[i] = '0;
		pc_r = 0;
		base_r = 0;
		top_r = -1;
		errors = 0;
		pending = 0;
		results_seen = 0;
	end

	always @(posedge clk) begin
		mstate_t st, got, ex;
		if (arst_n && instr.valid && instr.ready) begin
			execute(func_t'(instr.func), int'(instr.level), instr.operand, st);
			state_q.push_back(st);
		end
		if (arst_n && result.valid && result.ready) begin
			got = '{result.next_pc, result.halted, result.top_index, result.top_value,
				result.frame_base, result.fault};
			results_seen++;
			if (state_q.size() == 0) begin
				$display("%t: unexpected result transaction: %p", $realtime, got);
				errors++;
			end else begin
				ex = state_q.pop_front();
				if (got.next_pc !== ex.next_pc) begin
					$display("%t: next_pc exp %0d got %0d", $realtime, ex.next_pc, got.next_pc);
					errors++;
				end
				if (got.halted !== ex.halted) begin
					$display("%t: halted exp %0d got %0d", $realtime, ex.halted, got.halted);
					errors++;
				end
				if (got.top_index !== ex.top_index) begin
					$display("%t: top_index exp %0d got %0d", $realtime, ex.top_index,
						got.top_index);
					errors++;
				end
				if (got.top_value !== ex.top_value) begin
					$display("%t: top_value exp %0d got %0d", $realtime, ex.top_value,
						got.top_value);
					errors++;
				end
				if (got.frame_base !== ex.frame_base) begin
					$display("%t: frame_base exp %0d got %0d", $realtime, ex.frame_base,
						got.frame_base);
					errors++;
				end
				if (got.fault !== ex.fault) begin
					$display("%t: fault exp %0d got %0d", $realtime, ex.fault, got.fault);
					errors++;
				end
			end
		end
		pending = state_q.size();
	end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench top for the p-code executor. Runs a short directed program
// through every opcode and operator, then about 1200 random instructions
// weighted toward stack-balanced sequences, with random idle bursts on both
// channels, one long result stall and one drain pause. The checker does
// all prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import pcsm_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int RAND_ITEMS = 1200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int errors, pending, results_seen;
	int sent = 0;
	int idle_cycles = 0;
	bit calm = 0;
	bit long_hold = 0;
	bit long_done = 0;
	int hold_cnt = 0;
	int stall_cnt = 0;

	pcsm_instr_if  instr_ch();
	pcsm_result_if res_ch();

	pcode_stack_machine_execute dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_ch),
		.result (res_ch)
	);

	pcsm_exec_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.instr        (instr_ch),
		.result       (res_ch),
		.errors       (errors),
		.pending      (pending),
		.results_seen (results_seen)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((instr_ch.valid && instr_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_cnt <= 0;
			hold_cnt <= 0;
		end else if (long_hold && !long_done) begin
			res_ch.ready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt == 300)
				long_done <= 1;
		end else if (stall_cnt > 0) begin
			res_ch.ready <= 1'b0;
			stall_cnt <= stall_cnt - 1;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			res_ch.ready <= 1'b0;
			stall_cnt <= $urandom_range(0, 6);
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	task automatic send(func_t f, int lev, int opd);
		instr_ch.valid <= 1'b1;
		instr_ch.func <= f;
		instr_ch.level <= LEV_W'(lev);
		instr_ch.operand <= OPD_W'(opd);
		do
			@(posedge clk);
		while (!instr_ch.ready);
		sent++;
		if (!calm && $urandom_range(0, 5) == 0) begin
			instr_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	function automatic int small_or_full(int lo, int hi);
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(lo, hi);
	endfunction

	task automatic send_random();
		logic [OPD_W-1:0] binops [10] = '{OPR_ADD, OPR_SUB, OPR_MUL, OPR_DIV, OPR_EQL,
			OPR_NEQ, OPR_LSS, OPR_GEQ, OPR_GTR, OPR_LEQ};
		int sel, k;
		sel = $urandom_range(0, 99);
		if (sel < 25) begin
			send(F_LIT, $urandom_range(0, 3), small_or_full(0, 9));
		end else if (sel < 50) begin
			k = $urandom_range(0, 19);
			if (k < 12) send(F_OPR, $urandom_range(0, 3), binops[$urandom_range(0, 9)]);
			else if (k < 14) send(F_OPR, 0, OPR_NEG);
			else if (k < 16) send(F_OPR, 0, OPR_ODD);
			else if (k < 18) send(F_OPR, 0, OPR_RET);
			else if (k < 19) send(F_OPR, 0, 7);
			else send(F_OPR, $urandom_range(0, 3), $urandom_range(14, 2047));
		end else if (sel < 60) begin
			send(F_LOD, $urandom_range(0, 3), small_or_full(0, 12));
		end else if (sel < 70) begin
			send(F_STO, $urandom_range(0, 3), small_or_full(0, 12));
		end else if (sel < 75) begin
			send(F_CAL, $urandom_range(0, 3), $urandom_range(0, 2047));
		end else if (sel < 83) begin
			send(F_INT, 0, ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2047)
				: $urandom_range(0, 4));
		end else if (sel < 89) begin
			send(F_JMP, $urandom_range(0, 3), $urandom_range(0, 2047));
		end else begin
			send(F_JPC, $urandom_range(0, 3), $urandom_range(0, 2047));
		end
	endtask

	initial begin
		instr_ch.valid <= 1'b0;
		instr_ch.func <= F_LIT;
		instr_ch.level <= '0;
		instr_ch.operand <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed program
		send(F_OPR, 0, OPR_ADD);
		send(F_JPC, 0, 5);
		send(F_LIT, 0, 2047);
		send(F_OPR, 0, OPR_NEG);
		send(F_OPR, 0, OPR_ODD);
		send(F_LIT, 3, 0);
		send(F_OPR, 0, OPR_DIV);
		send(F_LIT, 0, 1000);
		send(F_OPR, 0, OPR_NEG);
		send(F_LIT, 0, 7);
		send(F_OPR, 0, OPR_DIV);
		send(F_LIT, 0, 3);
		send(F_OPR, 0, OPR_MUL);
		send(F_LIT, 0, 9);
		send(F_OPR, 0, OPR_SUB);
		for (int i = 0; i < 6; i++) begin
			send(F_LIT, 0, 5 + i);
			send(F_OPR, 0, (i == 0) ? OPR_EQL : (i == 1) ? OPR_NEQ : (i == 2) ? OPR_LSS
				: (i == 3) ? OPR_GEQ : (i == 4) ? OPR_GTR : OPR_LEQ);
		end
		send(F_OPR, 0, 7);
		send(F_OPR, 0, 2047);
		send(F_INT, 0, 4);
		send(F_STO, 0, 2);
		send(F_CAL, 3, 100);
		send(F_INT, 0, 3);
		send(F_LOD, 1, 2);
		send(F_OPR, 0, OPR_RET);
		send(F_INT, 0, 2047);
		send(F_INT, 0, 2047);
		send(F_JMP, 0, 0);
		send(F_JPC, 0, 2047);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == 400)
				long_hold = 1;
			if (n == 800) begin
				instr_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			if (n == 1000)
				calm = 1;
			send_random();
		end
		instr_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		$display("Covered %0d instructions (directed and random), %0d results checked,",
			sent, results_seen);
		$display("with idle bursts, a long result stall and a drain pause.");
		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
